// File: hw/rtl/cls_pkg.sv
// Shared types, codes and constants of the cyclic load sequencer.
package cls_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int SLOW_FACTOR = 200;
    localparam int NEAR_W      = 40;

    localparam logic [2:0] MODE_FORCE = 3'd0;
    localparam logic [2:0] MODE_DIST  = 3'd1;
    localparam logic [2:0] MODE_START = 3'd2;
    localparam logic [2:0] MODE_STOP  = 3'd3;
    localparam logic [2:0] MODE_RESET = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_KIND   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_THR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_THR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAGE_LENGTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_TOTAL  = 3'd6;

    localparam logic [30:0] FORCE_THR_RST   = 31'd300;
    localparam logic [30:0] DIST_THR_RST    = 31'd100;
    localparam logic [15:0] CYCLE_TOTAL_RST = 16'd1;

    typedef enum logic [1:0] {
        PH_STOP = 2'd0,
        PH_RUN  = 2'd1,
        PH_BACK = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BWD  = 2'd2
    } dir_t;

    typedef enum logic [2:0] {
        MV_NONE = 3'd0,
        MV_FWD  = 3'd1,
        MV_BWD  = 3'd2,
        MV_GAGE = 3'd3,
        MV_STOP = 3'd4
    } motion_t;

    typedef enum logic [1:0] {
        SP_KEEP  = 2'd0,
        SP_FULL  = 2'd1,
        SP_TENTH = 2'd2
    } speed_t;

    typedef struct packed {
        logic               limit_kind;
        logic signed [31:0] force_limit;
        logic [30:0]        force_threshold;
        logic signed [31:0] distance_limit;
        logic [30:0]        distance_threshold;
        logic [NEAR_W-1:0]  distance_near;
        logic signed [31:0] gage_length;
        logic [15:0]        cycle_total;
    } cls_cfg_t;

    typedef struct packed {
        motion_t     motion_cmd;
        speed_t      speed_cmd;
        logic        finished;
        phase_t      phase;
        logic [15:0] cycle_index;
    } cls_result_t;

endpackage

// File: hw/rtl/cls_in_if.sv
// Input channel: event or sample word with valid/ready.
interface cls_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic signed [31:0] sample_value;

    modport source (output valid, output mode, output sample_value, input ready);
    modport sink   (input valid, input mode, input sample_value, output ready);
endinterface

// File: hw/rtl/cls_out_if.sv
// Output channel: command word with valid/ready.
interface cls_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  motion_cmd;
    logic [1:0]  speed_cmd;
    logic        finished;
    logic [1:0]  phase;
    logic [15:0] cycle_index;

    modport source (output valid, output motion_cmd, output speed_cmd, output finished,
                    output phase, output cycle_index, input ready);
    modport sink   (input valid, input motion_cmd, input speed_cmd, input finished,
                    input phase, input cycle_index, output ready);
endinterface

// File: hw/rtl/cls_cfg.sv
// Configuration register bank, with the slow-zone width precomputed on write.
module cls_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cls_pkg::CFG_DATA_W-1:0] cfg_data,
    output cls_pkg::cls_cfg_t             cfg
);
    import cls_pkg::*;

    cls_cfg_t cfg_reg;
    cls_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LIMIT_KIND:  cfg_next.limit_kind = cfg_data[0];
                REG_FORCE_LIMIT: cfg_next.force_limit = signed'(cfg_data);
                REG_FORCE_THR:   cfg_next.force_threshold = cfg_data[30:0];
                REG_DIST_LIMIT:  cfg_next.distance_limit = signed'(cfg_data);
                REG_DIST_THR:
                begin
                    cfg_next.distance_threshold = cfg_data[30:0];
                    cfg_next.distance_near = NEAR_W'(cfg_data[30:0]) * NEAR_W'(SLOW_FACTOR);
                end
                REG_GAGE_LENGTH: cfg_next.gage_length = signed'(cfg_data);
                REG_CYCLE_TOTAL: cfg_next.cycle_total = cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit_kind         <= 1'b0;
            cfg_reg.force_limit        <= '0;
            cfg_reg.force_threshold    <= FORCE_THR_RST;
            cfg_reg.distance_limit     <= '0;
            cfg_reg.distance_threshold <= DIST_THR_RST;
            cfg_reg.distance_near      <= NEAR_W'(SLOW_FACTOR) * NEAR_W'(DIST_THR_RST);
            cfg_reg.gage_length        <= '0;
            cfg_reg.cycle_total        <= CYCLE_TOTAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

// File: hw/rtl/cls_step.sv
// Sequencer state and the per-word next-state and command logic.
module cls_step (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic [2:0]            mode,
    input  logic signed [31:0]    sample_value,
    input  cls_pkg::cls_cfg_t     cfg,
    output cls_pkg::cls_result_t  result
);
    import cls_pkg::*;

    phase_t             phase_reg, phase_next;
    dir_t               dir_reg, dir_next;
    logic [15:0]        cycle_reg, cycle_next;
    logic               slow_reg, slow_next;
    logic signed [31:0] force_reg, force_next;
    logic signed [31:0] dist_reg, dist_next;

    logic signed [33:0] f_over, f_under, d_over, d_under, g_over, g_under;
    logic signed [33:0] f_thr, d_thr;
    logic signed [NEAR_W:0] near_s;
    logic f_hi, f_lo, d_hi, d_lo, d_near, at_gage, last_cycle;
    motion_t mv;
    speed_t  sp;
    logic    fin;

    always_comb
    begin
        force_next = (mode == MODE_FORCE) ? sample_value : force_reg;
        dist_next  = (mode == MODE_DIST)  ? sample_value : dist_reg;
    end

    // 34-bit differences never wrap
    assign f_thr   = signed'({3'b000, cfg.force_threshold});
    assign d_thr   = signed'({3'b000, cfg.distance_threshold});
    assign f_over  = 34'(force_next) - 34'(cfg.force_limit);
    assign f_under = 34'(cfg.force_limit) - 34'(force_next);
    assign d_over  = 34'(dist_next) - 34'(cfg.distance_limit);
    assign d_under = 34'(cfg.distance_limit) - 34'(dist_next);
    assign g_over  = 34'(cfg.gage_length) - 34'(dist_next);
    assign g_under = 34'(dist_next) - 34'(cfg.gage_length);
    assign near_s  = signed'({1'b0, cfg.distance_near});

    assign f_hi       = f_over > f_thr;
    assign f_lo       = f_under > f_thr;
    assign d_hi       = d_over > d_thr;
    assign d_lo       = d_under > d_thr;
    assign d_near     = ((NEAR_W+1)'(d_over) < near_s) || ((NEAR_W+1)'(d_under) < near_s);
    assign at_gage    = (g_over < d_thr) && (g_under < d_thr);
    assign last_cycle = {1'b0, cfg.cycle_total} <= ({1'b0, cycle_reg} + 17'd1);

    always_comb
    begin
        phase_next = phase_reg;
        dir_next   = dir_reg;
        cycle_next = cycle_reg;
        slow_next  = slow_reg;
        mv         = MV_NONE;
        sp         = SP_KEEP;
        fin        = 1'b0;
        case (mode)
            MODE_FORCE, MODE_DIST:
            begin
                case (phase_reg)
                    PH_RUN:
                    begin
                        if (cfg.limit_kind)
                        begin
                            if (f_hi)
                            begin
                                if (dir_reg != DIR_BWD)
                                begin
                                    dir_next = DIR_BWD;
                                    mv       = MV_BWD;
                                end
                            end
                            else if (f_lo)
                            begin
                                if (dir_reg != DIR_FWD)
                                begin
                                    dir_next = DIR_FWD;
                                    mv       = MV_FWD;
                                end
                            end
                            else
                            begin
                                phase_next = PH_BACK;
                                mv         = MV_GAGE;
                            end
                        end
                        else
                        begin
                            if (d_near && !slow_reg)
                            begin
                                slow_next = 1'b1;
                                sp        = SP_TENTH;
                            end
                            if (d_hi)
                            begin
                                if (dir_reg != DIR_FWD)
                                begin
                                    dir_next = DIR_FWD;
                                    mv       = MV_FWD;
                                end
                            end
                            else if (d_lo)
                            begin
                                if (dir_reg != DIR_BWD)
                                begin
                                    dir_next = DIR_BWD;
                                    mv       = MV_BWD;
                                end
                            end
                            else
                            begin
                                phase_next = PH_BACK;
                                sp         = SP_FULL;
                                mv         = MV_GAGE;
                            end
                        end
                    end
                    PH_BACK:
                    begin
                        if (at_gage)
                        begin
                            if (last_cycle)
                            begin
                                phase_next = PH_STOP;
                                cycle_next = '0;
                                dir_next   = DIR_STOP;
                                fin        = 1'b1;
                            end
                            else
                            begin
                                cycle_next = cycle_reg + 16'd1;
                                phase_next = PH_RUN;
                                // new cycle heads the opposite way to a force run update
                                if (cfg.limit_kind)
                                begin
                                    if (f_hi)
                                    begin
                                        dir_next = DIR_FWD;
                                        mv       = MV_FWD;
                                        sp       = SP_FULL;
                                    end
                                    else if (f_lo)
                                    begin
                                        dir_next = DIR_BWD;
                                        mv       = MV_BWD;
                                        sp       = SP_FULL;
                                    end
                                end
                                else
                                begin
                                    if (d_hi)
                                    begin
                                        slow_next = 1'b0;
                                        dir_next  = DIR_FWD;
                                        mv        = MV_FWD;
                                        sp        = SP_FULL;
                                    end
                                    else if (d_lo)
                                    begin
                                        slow_next = 1'b0;
                                        dir_next  = DIR_BWD;
                                        mv        = MV_BWD;
                                        sp        = SP_FULL;
                                    end
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            MODE_START:
            begin
                if (phase_reg == PH_STOP)
                begin
                    sp         = SP_FULL;
                    phase_next = PH_RUN;
                    if (cfg.limit_kind)
                    begin
                        if (f_hi)
                        begin
                            dir_next = DIR_BWD;
                            mv       = MV_BWD;
                        end
                        else if (f_lo)
                        begin
                            dir_next = DIR_FWD;
                            mv       = MV_FWD;
                        end
                    end
                    else
                    begin
                        if (d_hi)
                        begin
                            dir_next = DIR_FWD;
                            mv       = MV_FWD;
                        end
                        else if (d_lo)
                        begin
                            dir_next = DIR_BWD;
                            mv       = MV_BWD;
                        end
                    end
                end
            end
            MODE_STOP:
            begin
                if (phase_reg == PH_RUN)
                begin
                    phase_next = PH_STOP;
                    dir_next   = DIR_STOP;
                    cycle_next = '0;
                    mv         = MV_STOP;
                    fin        = 1'b1;
                end
            end
            MODE_RESET:
            begin
                phase_next = PH_STOP;
                dir_next   = DIR_STOP;
                cycle_next = '0;
                mv         = MV_STOP;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_STOP;
            dir_reg   <= DIR_STOP;
            cycle_reg <= '0;
            slow_reg  <= 1'b0;
            force_reg <= '0;
            dist_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            dir_reg   <= dir_next;
            cycle_reg <= cycle_next;
            slow_reg  <= slow_next;
            force_reg <= force_next;
            dist_reg  <= dist_next;
        end
    end

    always_comb
    begin
        result.motion_cmd  = mv;
        result.speed_cmd   = sp;
        result.finished    = fin;
        result.phase       = phase_next;
        result.cycle_index = cycle_next;
    end
endmodule

// File: hw/rtl/cyclic_load_sequencer.sv
// Top level of the cyclic load sequencer: input register, step logic, result register.
// Every input word (sample, start, stop or reset event) gives exactly one command word.
// A word passes through an input register and then through the step logic into the result
// register, from which the command word is offered; one word can be taken every cycle while
// the sink does not stall. The result register only holds a word back while the sink
// stalls; then the input register fills and ready drops. The sequencer state (phase,
// direction, cycle count, slow flag, latest force and distance) advances as each word
// leaves the input register. Configuration writes take effect on the next clock and
// should be made while no word is in flight. There is no clearing pass after reset.
module cyclic_load_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    cls_in_if.sink                         in_ch,
    cls_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [cls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cls_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cls_pkg::*;

    logic               in_valid_reg;
    logic [2:0]         mode_reg;
    logic signed [31:0] sample_reg;
    logic               out_valid_reg;
    cls_result_t        res_reg;
    cls_result_t        step_res;
    cls_cfg_t           cfg;
    logic               advance;

    cls_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cls_step u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (advance),
        .mode         (mode_reg),
        .sample_value (sample_reg),
        .cfg          (cfg),
        .result       (step_res)
    );

    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            mode_reg   <= in_ch.mode;
            sample_reg <= in_ch.sample_value;
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.motion_cmd  = res_reg.motion_cmd;
    assign out_ch.speed_cmd   = res_reg.speed_cmd;
    assign out_ch.finished    = res_reg.finished;
    assign out_ch.phase       = res_reg.phase;
    assign out_ch.cycle_index = res_reg.cycle_index;

    // a run that ends always leaves the sequencer stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.finished |-> res_reg.phase == PH_STOP)
        else $error("finished word without stopped phase");

    // cycle count is cleared on every way into the stopped phase
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.phase == PH_STOP |-> res_reg.cycle_index == 16'd0)
        else $error("stopped with non-zero cycle count");

    // goto gage length is only issued on the turn into the returning phase
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.motion_cmd == MV_GAGE |-> res_reg.phase == PH_BACK)
        else $error("goto gage length outside returning phase");

    // a word leaving the input register is offered on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("stepped word lost");
endmodule

// File: tb/tb_cyclic_load_sequencer.sv
// Self-checking testbench of the cyclic load sequencer: directed and random load runs.
`timescale 1ns / 100ps

import cls_pkg::*;

class command_scoreboard;
    logic        limit_kind;
    longint      force_limit;
    longint      force_thr;
    longint      dist_limit;
    longint      dist_thr;
    longint      gage;
    logic [15:0] cycle_total;

    phase_t      phase;
    dir_t        dir;
    logic [15:0] cycle_cnt;
    logic        slow;
    longint      last_force;
    longint      last_dist;

    cls_result_t expected_cmds[$];
    int          errors;

    function new();
        limit_kind  = 1'b0;
        force_limit = 0;
        force_thr   = longint'(FORCE_THR_RST);
        dist_limit  = 0;
        dist_thr    = longint'(DIST_THR_RST);
        gage        = 0;
        cycle_total = CYCLE_TOTAL_RST;
        phase       = PH_STOP;
        dir         = DIR_STOP;
        cycle_cnt   = '0;
        slow        = 1'b0;
        last_force  = 0;
        last_dist   = 0;
        errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_LIMIT_KIND:  limit_kind  = data[0];
            REG_FORCE_LIMIT: force_limit = longint'($signed(data));
            REG_FORCE_THR:   force_thr   = longint'(data[30:0]);
            REG_DIST_LIMIT:  dist_limit  = longint'($signed(data));
            REG_DIST_THR:    dist_thr    = longint'(data[30:0]);
            REG_GAGE_LENGTH: gage        = longint'($signed(data));
            REG_CYCLE_TOTAL: cycle_total = data[15:0];
            default: ;
        endcase
    endfunction

    // +1 above the band, -1 below it, 0 inside
    function int side(longint s, longint lim, longint thr);
        if (s - lim > thr)
            return 1;
        if (lim - s > thr)
            return -1;
        return 0;
    endfunction

    function void run_update(inout motion_t mv, inout speed_t sp);
        int s;
        longint near_band;
        if (limit_kind)
        begin
            s = side(last_force, force_limit, force_thr);
            if (s > 0)
            begin
                if (dir == DIR_FWD || dir == DIR_STOP)
                begin
                    dir = DIR_BWD;
                    mv  = MV_BWD;
                end
            end
            else if (s < 0)
            begin
                if (dir == DIR_BWD || dir == DIR_STOP)
                begin
                    dir = DIR_FWD;
                    mv  = MV_FWD;
                end
            end
            else
            begin
                phase = PH_BACK;
                mv    = MV_GAGE;
            end
        end
        else
        begin
            near_band = longint'(SLOW_FACTOR) * dist_thr;
            if ((last_dist - dist_limit) < near_band || (dist_limit - last_dist) < near_band)
            begin
                if (!slow)
                begin
                    slow = 1'b1;
                    sp   = SP_TENTH;
                end
            end
            s = side(last_dist, dist_limit, dist_thr);
            if (s > 0)
            begin
                if (dir == DIR_BWD || dir == DIR_STOP)
                begin
                    dir = DIR_FWD;
                    mv  = MV_FWD;
                end
            end
            else if (s < 0)
            begin
                if (dir == DIR_FWD || dir == DIR_STOP)
                begin
                    dir = DIR_BWD;
                    mv  = MV_BWD;
                end
            end
            else
            begin
                phase = PH_BACK;
                sp    = SP_FULL;
                mv    = MV_GAGE;
            end
        end
    endfunction

    function void back_update(inout motion_t mv, inout speed_t sp, inout logic fin);
        longint gap;
        int s;
        gap = gage - last_dist;
        if (gap < 0)
            gap = -gap;
        if (!(gap < dist_thr))
            return;
        if (longint'(cycle_total) - 1 <= longint'(cycle_cnt))
        begin
            phase     = PH_STOP;
            cycle_cnt = '0;
            dir       = DIR_STOP;
            fin       = 1'b1;
            return;
        end
        cycle_cnt = cycle_cnt + 16'd1;
        phase     = PH_RUN;
        if (limit_kind)
            s = side(last_force, force_limit, force_thr);
        else
            s = side(last_dist, dist_limit, dist_thr);
        if (s != 0)
        begin
            if (!limit_kind)
                slow = 1'b0;
            dir = (s > 0) ? DIR_FWD : DIR_BWD;
            mv  = (s > 0) ? MV_FWD : MV_BWD;
            sp  = SP_FULL;
        end
    endfunction

    function void start_run(inout motion_t mv, inout speed_t sp);
        int s;
        sp    = SP_FULL;
        phase = PH_RUN;
        if (limit_kind)
        begin
            // force run moves against the error
            s = -side(last_force, force_limit, force_thr);
        end
        else
            s = side(last_dist, dist_limit, dist_thr);
        if (s > 0)
        begin
            dir = DIR_FWD;
            mv  = MV_FWD;
        end
        else if (s < 0)
        begin
            dir = DIR_BWD;
            mv  = MV_BWD;
        end
    endfunction

    function cls_result_t next_command(logic [2:0] mode, logic signed [31:0] value);
        cls_result_t r;
        motion_t mv;
        speed_t sp;
        logic fin;
        mv  = MV_NONE;
        sp  = SP_KEEP;
        fin = 1'b0;
        case (mode)
            MODE_FORCE, MODE_DIST:
            begin
                if (mode == MODE_FORCE)
                    last_force = longint'(value);
                else
                    last_dist = longint'(value);
                if (phase == PH_RUN)
                    run_update(mv, sp);
                else if (phase == PH_BACK)
                    back_update(mv, sp, fin);
            end
            MODE_START:
            begin
                if (phase == PH_STOP)
                    start_run(mv, sp);
            end
            MODE_STOP:
            begin
                if (phase == PH_RUN)
                begin
                    phase     = PH_STOP;
                    dir       = DIR_STOP;
                    cycle_cnt = '0;
                    mv        = MV_STOP;
                    fin       = 1'b1;
                end
            end
            MODE_RESET:
            begin
                cycle_cnt = '0;
                phase     = PH_STOP;
                dir       = DIR_STOP;
                mv        = MV_STOP;
            end
            default: ;
        endcase
        r.motion_cmd  = mv;
        r.speed_cmd   = sp;
        r.finished    = fin;
        r.phase       = phase;
        r.cycle_index = cycle_cnt;
        return r;
    endfunction

    function void note_word(logic [2:0] mode, logic signed [31:0] value);
        expected_cmds.push_back(next_command(mode, value));
    endfunction

    function void check_word(logic [2:0] mv, logic [1:0] sp, logic fin, logic [1:0] ph,
                             logic [15:0] idx);
        cls_result_t want;
        if (expected_cmds.size() == 0)
        begin
            $error("command word with none expected");
            errors++;
            return;
        end
        want = expected_cmds.pop_front();
        if (mv !== want.motion_cmd)
        begin
            $error("motion_cmd: expected %0d, got %0d", want.motion_cmd, mv);
            errors++;
        end
        if (sp !== want.speed_cmd)
        begin
            $error("speed_cmd: expected %0d, got %0d", want.speed_cmd, sp);
            errors++;
        end
        if (fin !== want.finished)
        begin
            $error("finished: expected %0d, got %0d", want.finished, fin);
            errors++;
        end
        if (ph !== want.phase)
        begin
            $error("phase: expected %0d, got %0d", want.phase, ph);
            errors++;
        end
        if (idx !== want.cycle_index)
        begin
            $error("cycle_index: expected %0d, got %0d", want.cycle_index, idx);
            errors++;
        end
    endfunction
endclass

module tb_cyclic_load_sequencer;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     HOLD_CYCLES    = 150;
    localparam int     RUN_GOAL       = 34;
    localparam longint S32_MAX        = 64'sd2147483647;
    localparam longint S32_MIN        = -64'sd2147483648;
    localparam logic [2:0] MODE_UNDEF_LO = 3'd5;
    localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cls_in_if  in_ch();
    cls_out_if out_ch();

    cyclic_load_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    command_scoreboard sb = new();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int sent          = 0;
    int quiet         = 0;
    int idle_tab[4]   = '{0, 82, 0, 8};
    int stall_tab[4]  = '{0, 0, 82, 8};

    logic   cur_kind;
    longint cur_fl, cur_ft, cur_dl, cur_dt, cur_gl;
    int     cur_ct;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_word(in_ch.mode, in_ch.sample_value);
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_word(out_ch.motion_cmd, out_ch.speed_cmd, out_ch.finished,
                          out_ch.phase, out_ch.cycle_index);
        if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // sink side: random stalls, or a counted hold-off when requested
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic signed [31:0] sat32(longint v);
        if (v > S32_MAX)
            return 32'sh7FFF_FFFF;
        if (v < S32_MIN)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // random offset inside a band; strict bands exclude the edge
    function automatic longint band_jitter(longint thr, bit strict);
        longint lim;
        lim = strict ? thr - 1 : thr;
        if (lim > 1000)
            lim = 1000;
        if (lim <= 0)
            return 0;
        return longint'($urandom_range(32'(2 * lim))) - lim;
    endfunction

    function automatic longint far_offset();
        longint mag;
        mag = cur_ft + longint'($urandom_range(1, 60000));
        return $urandom_range(1) ? mag : -mag;
    endfunction

    task automatic send_word(input logic [2:0] m, input logic signed [31:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= m;
        in_ch.sample_value <= v;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic send_mixed(input logic [2:0] m, input logic signed [31:0] v);
        if ($urandom_range(11) == 0)
            send_word(3'($urandom_range(7)), $urandom);
        send_word(m, v);
        sent++;
    endtask

    task automatic ramp(input logic [2:0] m, input longint from, input longint to,
                        input int steps);
        for (int i = 1; i <= steps; i++)
            send_mixed(m, sat32(from + (to - from) * i / steps));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_cmds.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic apply_config(input logic kind, input longint fl, input longint ft,
                                input longint dl, input longint dt, input longint gl,
                                input int ct);
        drain();
        set_reg(REG_LIMIT_KIND, {31'd0, kind});
        set_reg(REG_FORCE_LIMIT, fl[31:0]);
        set_reg(REG_FORCE_THR, {1'b0, ft[30:0]});
        set_reg(REG_DIST_LIMIT, dl[31:0]);
        set_reg(REG_DIST_THR, {1'b0, dt[30:0]});
        set_reg(REG_GAGE_LENGTH, gl[31:0]);
        set_reg(REG_CYCLE_TOTAL, {16'd0, ct[15:0]});
        cfg_we   <= 1'b0;
        cur_kind = kind;
        cur_fl   = fl;
        cur_ft   = ft;
        cur_dl   = dl;
        cur_dt   = dt;
        cur_gl   = gl;
        cur_ct   = ct;
    endtask

    task automatic random_config();
        apply_config(1'($urandom_range(1)),
                     longint'($urandom_range(200000)) - 100000,
                     longint'($urandom_range(20, 2000)),
                     longint'($urandom_range(200000)) - 100000,
                     longint'($urandom_range(2, 1500)),
                     longint'($urandom_range(200000)) - 100000,
                     $urandom_range(1, 4));
    endtask

    // one run: start, load cycles toward the limit and back to gage length
    task automatic load_run();
        int cycles;
        longint pos;
        longint target;
        if ($urandom_range(9) == 0)
            send_mixed(MODE_RESET, $urandom);
        pos = cur_gl + band_jitter(cur_dt, 1'b1);
        send_mixed(MODE_DIST, sat32(pos));
        if (cur_kind)
            send_mixed(MODE_FORCE, sat32(cur_fl + far_offset()));
        send_mixed(MODE_START, $urandom);
        if (cur_ct == 0 || cur_ct > 3)
            cycles = $urandom_range(1, 3);
        else
            cycles = cur_ct + ($urandom_range(3) == 0);
        repeat (cycles)
        begin
            if (cur_kind)
            begin
                ramp(MODE_FORCE, cur_fl + far_offset(), cur_fl + band_jitter(cur_ft, 1'b0),
                     $urandom_range(1, 5));
                pos = cur_dl;
            end
            else
                ramp(MODE_DIST, pos, cur_dl + band_jitter(cur_dt, 1'b0), $urandom_range(1, 6));
            if ($urandom_range(7) == 0)
                send_mixed(MODE_STOP, $urandom);
            target = cur_gl + band_jitter(cur_dt, 1'b1);
            ramp(MODE_DIST, pos, target, $urandom_range(1, 5));
            pos = target;
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.mode         <= MODE_FORCE;
        in_ch.sample_value <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_LIMIT_KIND;
        cfg_data           <= '0;
        cur_kind = 1'b0;
        cur_fl   = 0;
        cur_ft   = longint'(FORCE_THR_RST);
        cur_dl   = 0;
        cur_dt   = longint'(DIST_THR_RST);
        cur_gl   = 0;
        cur_ct   = 1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset configuration
        send_word(MODE_UNDEF_LO, 32'sh7FFF_FFFF);
        send_word(MODE_UNDEF_HI, 32'sh8000_0000);
        send_word(MODE_STOP, '0);
        send_word(MODE_DIST, 32'sh8000_0000);
        send_word(MODE_START, '0);
        send_word(MODE_START, '0);
        send_word(MODE_DIST, 32'sh7FFF_FFFF);
        send_word(MODE_DIST, 32'sd50);
        send_word(MODE_STOP, '0);
        send_word(MODE_FORCE, 32'sd12345);
        send_word(MODE_START, '0);
        send_word(MODE_STOP, '0);
        send_word(MODE_RESET, '1);

        // directed, extreme force configuration with zero cycle total
        apply_config(1'b1, S32_MAX, 0, S32_MIN, S32_MAX, S32_MIN, 0);
        send_word(MODE_FORCE, 32'sh8000_0000);
        send_word(MODE_START, '0);
        send_word(MODE_FORCE, 32'sh7FFF_FFFF);
        send_word(MODE_DIST, '0);
        send_word(MODE_DIST, 32'sh8000_0000);
        send_word(MODE_START, '0);
        send_word(MODE_RESET, '0);

        for (int p = 0; p < 4; p++)
        begin
            for (int s = 0; s < 3; s++)
            begin
                if (p == 3 && s == 1)
                    apply_config(1'b0, S32_MIN, 0, S32_MAX, 0, S32_MIN, 65535);
                else if (p == 3 && s == 2)
                    apply_config(1'b1, S32_MAX, S32_MAX, S32_MIN, S32_MAX, S32_MAX, 65535);
                else
                    random_config();
                send_idle_pct = idle_tab[p];
                stall_pct     = stall_tab[p];
                if (p == 0 && s == 1)
                    hold_left = HOLD_CYCLES;
                sent = 0;
                while (sent < RUN_GOAL)
                    load_run();
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.expected_cmds.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
